[hdl/primitive_list_expander_assert.svh]
// primitive_list_expander_assert.svh
// assertion macros shared by the primitive list expander modules
// expects signals named clk and rst_n in the including scope
`ifndef PRIMITIVE_LIST_EXPANDER_ASSERT_SVH
`define PRIMITIVE_LIST_EXPANDER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PLE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("primitive list expander check failed");

// next-cycle implication, disabled while in reset
`define PLE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("primitive list expander check failed");

`endif

[hdl/ple_pkg.sv]
// ple_pkg.sv
// shared types and constants of the primitive list expander
// no dependencies
package ple_pkg;

    // field widths
    localparam int IndexBits  = 16;
    localparam int ModeBits   = 4;
    localparam int CornerBits = 3;
    localparam int TopoBits   = 2;
    localparam int MaxResults = 6;
    localparam int CountBits  = 3;

    // job queue between front and back
    localparam int QueueDepth = 2;
    localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCntBits   = $clog2(QueueDepth + 1);

    // primitive modes
    localparam logic [ModeBits-1:0] MODE_TRIS    = 4'd0;
    localparam logic [ModeBits-1:0] MODE_QUADS   = 4'd1;
    localparam logic [ModeBits-1:0] MODE_QSTRIP  = 4'd2;
    localparam logic [ModeBits-1:0] MODE_FAN     = 4'd3;
    localparam logic [ModeBits-1:0] MODE_TSTRIP  = 4'd4;
    localparam logic [ModeBits-1:0] MODE_LINES   = 4'd5;
    localparam logic [ModeBits-1:0] MODE_LSTRIP  = 4'd6;
    localparam logic [ModeBits-1:0] MODE_LOOP    = 4'd7;
    localparam logic [ModeBits-1:0] MODE_POINTS  = 4'd8;

    // output topology codes
    localparam logic [TopoBits-1:0] TOPO_TRI   = 2'd0;
    localparam logic [TopoBits-1:0] TOPO_LINE  = 2'd1;
    localparam logic [TopoBits-1:0] TOPO_POINT = 2'd2;

    // last point corner code
    localparam logic [CornerBits-1:0] CORNER_LAST = 3'd6;

    typedef logic [IndexBits-1:0] index_t;

    // one expanded vertex: up to six indices emitted in order
    typedef struct packed {
        index_t [MaxResults-1:0] idx;
        logic [CountBits-1:0]    count;
        logic [TopoBits-1:0]     topology;
        logic                    is_point;
    } job_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hdl/ple_vertex_if.sv]
// ple_vertex_if.sv
// input channel: one vertex index per transfer with a batch end flag
// depends on ple_pkg
interface ple_vertex_if;
    logic                      valid;
    logic                      ready;
    logic [ple_pkg::IndexBits-1:0] vertex_index;
    logic                      batch_end;

    modport source (output valid, output vertex_index, output batch_end, input ready);
    modport sink   (input valid, input vertex_index, input batch_end, output ready);
endinterface

[hdl/ple_prim_if.sv]
// ple_prim_if.sv
// output channel: one expanded list vertex per transfer
// depends on ple_pkg
interface ple_prim_if;
    logic                           valid;
    logic                           ready;
    logic [ple_pkg::IndexBits-1:0]  out_index;
    logic [ple_pkg::CornerBits-1:0] corner;
    logic [ple_pkg::TopoBits-1:0]   topology;
    logic                           run_last;

    modport source (output valid, output out_index, output corner, output topology,
                    output run_last, input ready);
    modport sink   (input valid, input out_index, input corner, input topology,
                    input run_last, output ready);
endinterface

[hdl/ple_queue.sv]
// ple_queue.sv
// short job queue that decouples the classify front from the emit back
// depends on ple_pkg and primitive_list_expander_assert.svh
`include "primitive_list_expander_assert.svh"

module ple_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ple_pkg::job_t       push_job,
    input  logic                pop,
    output ple_pkg::job_t       head,
    output ple_pkg::q_status_t  status
);

    ple_pkg::job_t                  entries_reg [ple_pkg::QueueDepth];
    logic [ple_pkg::QPtrBits-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ple_pkg::QPtrBits-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ple_pkg::QCntBits-1:0]   count_reg, count_next;
    logic                           do_push, do_pop;

    localparam logic [ple_pkg::QPtrBits-1:0] PtrLast = ple_pkg::QPtrBits'(ple_pkg::QueueDepth - 1);
    localparam logic [ple_pkg::QCntBits-1:0] CntFull = ple_pkg::QCntBits'(ple_pkg::QueueDepth);

    // status
    assign status.full  = (count_reg == CntFull);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    // front never offers a job to a full queue
    `PLE_ASSERT_IMP(a_no_push_full, push, !status.full)
    // back never pops an empty queue
    `PLE_ASSERT_IMP(a_no_pop_empty, pop, !status.empty)
    // fill count never passes the depth
    `PLE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CntFull)

endmodule

[hdl/ple_front.sv]
// ple_front.sv
// front end: vertex transfer, batch tracking and job classification by mode
// depends on ple_pkg, ple_vertex_if and primitive_list_expander_assert.svh
`include "primitive_list_expander_assert.svh"

module ple_front (
    input  logic                              clk,
    input  logic                              rst_n,
    ple_vertex_if.sink                        vtx_in,
    input  logic                              cfg_we,
    input  logic [ple_pkg::ModeBits-1:0]      cfg_wdata,
    input  ple_pkg::q_status_t                q_status,
    output logic                              job_push,
    output ple_pkg::job_t                     job
);

    logic [ple_pkg::ModeBits-1:0] mode_reg;
    ple_pkg::index_t              first_reg, first_next;
    ple_pkg::index_t              r0_reg, r1_reg, r2_reg;
    // batch position kept as saturating low count plus residues mod 3 and 4
    logic [1:0]                   pos_lo_reg, pos_lo_next;
    logic [1:0]                   mod3_reg, mod3_next;
    logic [1:0]                   mod4_reg, mod4_next;
    logic                         accept;
    logic                         last;
    ple_pkg::index_t              cur;
    logic                         pos_ge1, pos_ge2, pos_ge3, pos_odd;

    assign vtx_in.ready = !q_status.full;
    assign accept       = vtx_in.valid && vtx_in.ready;
    assign cur          = vtx_in.vertex_index;
    assign last         = vtx_in.batch_end;
    assign pos_ge1      = (pos_lo_reg != 2'd0);
    assign pos_ge2      = pos_lo_reg[1];
    assign pos_ge3      = (pos_lo_reg == 2'd3);
    assign pos_odd      = mod4_reg[0];
    assign first_next   = (pos_lo_reg == 2'd0) ? cur : first_reg;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ple_pkg::MODE_TRIS;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // batch position next values
    always_comb
    begin
        if (last)
        begin
            pos_lo_next = 2'd0;
            mod3_next   = 2'd0;
            mod4_next   = 2'd0;
        end
        else
        begin
            pos_lo_next = pos_ge3 ? pos_lo_reg : pos_lo_reg + 2'd1;
            mod3_next   = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            mod4_next   = mod4_reg + 2'd1;
        end
    end

    // batch state and recent vertex history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            r0_reg     <= '0;
            r1_reg     <= '0;
            r2_reg     <= '0;
            pos_lo_reg <= 2'd0;
            mod3_reg   <= 2'd0;
            mod4_reg   <= 2'd0;
        end
        else if (accept)
        begin
            first_reg  <= first_next;
            r2_reg     <= r1_reg;
            r1_reg     <= r0_reg;
            r0_reg     <= cur;
            pos_lo_reg <= pos_lo_next;
            mod3_reg   <= mod3_next;
            mod4_reg   <= mod4_next;
        end
    end

    // classify the vertex into an emit job
    always_comb
    begin
        job = '0;
        case (mode_reg)
            ple_pkg::MODE_TRIS:
            begin
                if (mod3_reg == 2'd2)
                begin
                    job.idx[0] = r1_reg;
                    job.idx[1] = r0_reg;
                    job.idx[2] = cur;
                    job.count  = 3'd3;
                end
            end
            ple_pkg::MODE_QUADS:
            begin
                if (mod4_reg == 2'd3)
                begin
                    job.idx[0] = r2_reg;
                    job.idx[1] = r1_reg;
                    job.idx[2] = r0_reg;
                    job.idx[3] = r2_reg;
                    job.idx[4] = r0_reg;
                    job.idx[5] = cur;
                    job.count  = 3'd6;
                end
            end
            ple_pkg::MODE_QSTRIP:
            begin
                if (pos_ge3 && pos_odd)
                begin
                    job.idx[0] = r2_reg;
                    job.idx[1] = r1_reg;
                    job.idx[2] = r0_reg;
                    job.idx[3] = r0_reg;
                    job.idx[4] = r1_reg;
                    job.idx[5] = cur;
                    job.count  = 3'd6;
                end
            end
            ple_pkg::MODE_FAN:
            begin
                if (pos_ge2)
                begin
                    job.idx[0] = first_next;
                    job.idx[1] = r0_reg;
                    job.idx[2] = cur;
                    job.count  = 3'd3;
                end
            end
            ple_pkg::MODE_TSTRIP:
            begin
                // odd strip triangles swap the first two to keep winding
                if (pos_ge2)
                begin
                    job.idx[0] = pos_odd ? r0_reg : r1_reg;
                    job.idx[1] = pos_odd ? r1_reg : r0_reg;
                    job.idx[2] = cur;
                    job.count  = 3'd3;
                end
            end
            ple_pkg::MODE_LINES:
            begin
                job.topology = ple_pkg::TOPO_LINE;
                if (pos_odd)
                begin
                    job.idx[0] = r0_reg;
                    job.idx[1] = cur;
                    job.count  = 3'd2;
                end
            end
            ple_pkg::MODE_LSTRIP:
            begin
                job.topology = ple_pkg::TOPO_LINE;
                if (pos_ge1)
                begin
                    job.idx[0] = r0_reg;
                    job.idx[1] = cur;
                    job.count  = 3'd2;
                end
            end
            ple_pkg::MODE_LOOP:
            begin
                // closing segment only when the loop has three or more vertices
                job.topology = ple_pkg::TOPO_LINE;
                if (pos_ge1)
                begin
                    job.idx[0] = r0_reg;
                    job.idx[1] = cur;
                    job.count  = 3'd2;
                end
                if (last && pos_ge2)
                begin
                    job.idx[2] = cur;
                    job.idx[3] = first_next;
                    job.count  = 3'd4;
                end
            end
            ple_pkg::MODE_POINTS:
            begin
                job.topology = ple_pkg::TOPO_POINT;
                job.is_point = 1'b1;
                job.idx      = {ple_pkg::MaxResults{cur}};
                job.count    = 3'd6;
            end
            default:
            begin
                job = '0;
            end
        endcase
    end

    assign job_push = accept && (job.count != '0);

    // a batch end restarts the position tracking
    `PLE_ASSERT_NXT(a_batch_restart, accept && last,
                    pos_lo_reg == 2'd0 && mod3_reg == 2'd0 && mod4_reg == 2'd0)
    // only legal result counts reach the queue
    `PLE_ASSERT_IMP(a_job_count, job_push,
                    job.count == 3'd2 || job.count == 3'd3 || job.count == 3'd4 ||
                    job.count == 3'd6)
    // point jobs always carry six corners
    `PLE_ASSERT_IMP(a_point_six, job_push && job.is_point,
                    job.count == 3'd6 && job.topology == ple_pkg::TOPO_POINT)

endmodule

[hdl/ple_back.sv]
// ple_back.sv
// back end: walks the head job one result per cycle into the output register while the output is ready
// depends on ple_pkg, ple_prim_if and primitive_list_expander_assert.svh
`include "primitive_list_expander_assert.svh"

module ple_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ple_pkg::job_t       head,
    input  ple_pkg::q_status_t  q_status,
    output logic                pop,
    ple_prim_if.source          prim_out
);

    logic [ple_pkg::CountBits-1:0]   sel_reg, sel_next;
    logic                            o_valid_reg, o_valid_next;
    ple_pkg::index_t                 o_index_reg;
    logic [ple_pkg::CornerBits-1:0]  o_corner_reg;
    logic [ple_pkg::TopoBits-1:0]    o_topo_reg;
    logic                            o_last_reg;
    logic                            load;
    logic                            at_end;

    // next result moves in when the output register is free or drains now
    assign load   = !q_status.empty && (!o_valid_reg || prim_out.ready);
    assign at_end = (sel_reg == head.count - 3'd1);
    assign pop    = load && at_end;

    always_comb
    begin
        sel_next = sel_reg;
        if (load)
        begin
            sel_next = at_end ? '0 : sel_reg + 3'd1;
        end
        o_valid_next = load ? 1'b1 : (prim_out.ready ? 1'b0 : o_valid_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg     <= sel_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_index_reg  <= head.idx[sel_reg];
            o_corner_reg <= head.is_point ? sel_reg + 3'd1 : '0;
            o_topo_reg   <= head.topology;
            o_last_reg   <= at_end;
        end
    end

    assign prim_out.valid     = o_valid_reg;
    assign prim_out.out_index = o_index_reg;
    assign prim_out.corner    = o_corner_reg;
    assign prim_out.topology  = o_topo_reg;
    assign prim_out.run_last  = o_last_reg;

    // step counter stays inside the head job
    `PLE_ASSERT_IMP(a_sel_in_job, !q_status.empty, sel_reg < head.count)
    // a point run ends on its sixth corner
    `PLE_ASSERT_IMP(a_point_end, o_valid_reg && o_last_reg && o_corner_reg != '0,
                    o_corner_reg == ple_pkg::CORNER_LAST)
    // after a job is popped the next one starts at its first entry
    `PLE_ASSERT_NXT(a_restart, pop, sel_reg == '0)

endmodule

[hdl/primitive_list_expander.sv]
// primitive_list_expander.sv
// top level: front classifier, job queue and emit back end
// depends on ple_pkg, ple_vertex_if, ple_prim_if, ple_front, ple_queue, ple_back
//
// Expands a stream of vertex indices in a legacy primitive mode into flat
// triangle, line or point-quad lists. An accepted vertex is classified
// combinationally and, if it completes primitives, becomes a job of 2, 3, 4 or
// 6 results in a two-entry queue; the back end sends one result per cycle
// through a registered output while the output is ready, so the single output
// port sets the sustained throughput. Input transfers continue while the queue
// has room, so vertices that emit nothing pass at one per cycle. The mode
// register may be written only while no results are pending.
module primitive_list_expander (
    input  logic                          clk,
    input  logic                          rst_n,
    ple_vertex_if.sink                    vtx_in,
    ple_prim_if.source                    prim_out,
    input  logic                          cfg_we,
    input  logic [ple_pkg::ModeBits-1:0]  cfg_wdata
);

    ple_pkg::job_t       push_job;
    ple_pkg::job_t       head_job;
    ple_pkg::q_status_t  q_status;
    logic                job_push;
    logic                job_pop;

    ple_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx_in   (vtx_in),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_status (q_status),
        .job_push (job_push),
        .job      (push_job)
    );

    ple_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .push_job(push_job),
        .pop     (job_pop),
        .head    (head_job),
        .status  (q_status)
    );

    ple_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_job),
        .q_status(q_status),
        .pop     (job_pop),
        .prim_out(prim_out)
    );

endmodule
